@@ design/itda_pkg.sv @@
// ----------------------------------------------------------------------------
// itda_pkg
// Shared widths, character codes and interface types of the integer to
// decimal ASCII converter.
// ----------------------------------------------------------------------------
package itda_pkg;

    localparam int VALUE_W    = 32;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int CHAR_W     = 8;
    localparam int COUNT_W    = 4;
    localparam int IDX_W      = 4;
    localparam int SHIFT_W    = 5;

    localparam logic CMD_SIGNED   = 1'b0;
    localparam logic CMD_UNSIGNED = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic             done;
        logic [BCD_W-1:0] bcd;
    } conv_result_t;

    typedef struct packed {
        logic             load;
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } emit_req_t;

endpackage

@@ design/itda_dabble.sv @@
// ----------------------------------------------------------------------------
// itda_dabble
// Bit-serial double-dabble converter: shifts the binary magnitude into a
// packed BCD register one bit per cycle, adjusting each digit before a shift.
// ----------------------------------------------------------------------------
module itda_dabble (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [itda_pkg::VALUE_W-1:0]  mag,
    output itda_pkg::conv_result_t        result
);
    import itda_pkg::*;

    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [BCD_W-1:0]   bcd_adj;
    logic [SHIFT_W-1:0] cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= 4'd5)
            begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + 4'd3;
            end
            else
            begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next  = mag;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == SHIFT_W'(VALUE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign result.done = done_reg;
    assign result.bcd  = bcd_reg;

endmodule

@@ design/itda_emitter.sv @@
// ----------------------------------------------------------------------------
// itda_emitter
// Character sequencer: finds the leading digit, then sends the optional
// minus sign and digits one item per unstalled cycle via an output register.
// ----------------------------------------------------------------------------
module itda_emitter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  itda_pkg::emit_req_t           req,
    output logic                          busy,
    output logic                          dst_valid,
    input  logic                          dst_stall,
    output logic [itda_pkg::CHAR_W-1:0]   ascii_char,
    output logic                          last,
    output logic [itda_pkg::COUNT_W-1:0]  char_count
);
    import itda_pkg::*;

    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic               pend_reg, pend_next;
    logic               neg_reg, neg_next;
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0]   top_idx;
    logic [DIGIT_W-1:0] digit;
    logic               advance;

    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (req.bcd[i*DIGIT_W +: DIGIT_W] != '0)
            begin
                top_idx = IDX_W'(i);
            end
        end
    end

    assign digit   = bcd_reg[idx_reg*DIGIT_W +: DIGIT_W];
    assign advance = pend_reg && (!out_valid_reg || !dst_stall);

    always_comb
    begin
        bcd_next       = bcd_reg;
        idx_next       = idx_reg;
        total_next     = total_reg;
        pend_next      = pend_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        if (out_valid_reg && !dst_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (req.load)
        begin
            pend_next  = 1'b1;
            neg_next   = req.neg;
            bcd_next   = req.bcd;
            idx_next   = top_idx;
            total_next = top_idx + COUNT_W'(1) + COUNT_W'(req.neg);
        end
        else if (advance)
        begin
            out_valid_next = 1'b1;
            if (neg_reg)
            begin
                neg_next   = 1'b0;
                char_next  = CHAR_MINUS;
                last_next  = 1'b0;
                count_next = '0;
            end
            else
            begin
                char_next = CHAR_ZERO + CHAR_W'(digit);
                if (idx_reg == '0)
                begin
                    pend_next  = 1'b0;
                    last_next  = 1'b1;
                    count_next = total_reg;
                end
                else
                begin
                    idx_next   = idx_reg - 1'b1;
                    last_next  = 1'b0;
                    count_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg   <= bcd_next;
        idx_reg   <= idx_next;
        total_reg <= total_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        count_reg <= count_next;
    end

    assign busy       = pend_reg;
    assign dst_valid  = out_valid_reg;
    assign ascii_char = char_reg;
    assign last       = last_reg;
    assign char_count = count_reg;

endmodule

@@ design/int_to_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// Converts a 32-bit value, signed or unsigned, into its decimal ASCII text,
// one character per output item, most significant first.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+------------------------------------
//   src     | src_valid, src_stall | cmd, value
//   dst     | dst_valid, dst_stall | ascii_char, last, char_count
//
// An item passes a load, 32 double-dabble shifts, a handoff, its characters
// (1 to 11), one per cycle while dst does not stall, and a return to idle.
// The bit-serial BCD shift register takes most of an unstalled item's time.
// A new item is taken only after the last character enters the output
// register and control is idle again. Reset clears the control state only.
// A stall on dst holds the character and adds its length to the item time.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          src_valid,
    output logic                          src_stall,
    input  logic                          cmd,
    input  logic [itda_pkg::VALUE_W-1:0]  value,
    output logic                          dst_valid,
    input  logic                          dst_stall,
    output logic [itda_pkg::CHAR_W-1:0]   ascii_char,
    output logic                          last,
    output logic [itda_pkg::COUNT_W-1:0]  char_count
);
    import itda_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic               neg_reg, neg_next;
    logic               accept;
    logic               neg_in;
    logic [VALUE_W-1:0] mag;
    logic               emit_busy;
    conv_result_t       conv;
    emit_req_t          req;

    assign src_stall = (state_reg != ST_IDLE);
    assign accept    = src_valid && !src_stall;
    assign neg_in    = (cmd == CMD_SIGNED) && value[VALUE_W-1];
    assign mag       = neg_in ? (~value + VALUE_W'(1)) : value;

    assign req.load = (state_reg == ST_CONV) && conv.done;
    assign req.neg  = neg_reg;
    assign req.bcd  = conv.bcd;

    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = neg_in;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (conv.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!emit_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            neg_reg   <= neg_next;
        end
    end

    itda_dabble u_dabble (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .mag    (mag),
        .result (conv)
    );

    itda_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .busy       (emit_busy),
        .dst_valid  (dst_valid),
        .dst_stall  (dst_stall),
        .ascii_char (ascii_char),
        .last       (last),
        .char_count (char_count)
    );

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> src_stall)
        else $error("Input taken while a conversion is running.");

    a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && last |-> char_count != '0)
        else $error("Final character carries no count.");

    a_mid_count: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !last |-> char_count == '0)
        else $error("Count shown on a non-final character.");

    a_minus_first: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && ascii_char == CHAR_MINUS |-> !last)
        else $error("Minus sign sent as the final character.");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !emit_busy)
        else $error("Emitter still busy while idle.");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the integer to decimal ASCII converter. Values
// in signed and unsigned mode go in on the source channel. A scoreboard
// works out the expected character text of each accepted item and checks
// every character that leaves the block, together with its last flag and
// count. Both sides idle at random, and one long receiver hold-off fills
// the block so that it stalls its input.
// ----------------------------------------------------------------------------
module tb;
    import itda_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 136;

    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic               fin;
        logic [COUNT_W-1:0] count;
    } dec_char_t;

    class dec_text_board;
        dec_char_t text_q[$];
        int        mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void note_number(logic mode, logic [VALUE_W-1:0] raw);
            logic               neg;
            logic [VALUE_W-1:0] mag;
            logic [DIGIT_W-1:0] digs[NUM_DIGITS];
            int                 nd;
            int                 total;
            dec_char_t          c;
            neg = (mode == CMD_SIGNED) && raw[VALUE_W-1];
            mag = neg ? (~raw + 1'b1) : raw;
            nd  = 0;
            do begin
                digs[nd] = DIGIT_W'(mag % 10);
                mag      = mag / 10;
                nd++;
            end while (mag != 0 && nd < NUM_DIGITS);
            total = nd + (neg ? 1 : 0);
            if (neg) begin
                c.ch    = CHAR_MINUS;
                c.fin   = 1'b0;
                c.count = '0;
                text_q.push_back(c);
            end
            for (int i = nd; i > 0; i--) begin
                c.ch    = CHAR_ZERO + CHAR_W'(digs[i-1]);
                c.fin   = (i == 1);
                c.count = (i == 1) ? COUNT_W'(total) : '0;
                text_q.push_back(c);
            end
        endfunction

        function void check_char(logic [CHAR_W-1:0] ch, logic fin,
                                 logic [COUNT_W-1:0] count);
            dec_char_t want;
            if (text_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected character %h last %b count %0d", ch, fin, count);
                return;
            end
            want = text_q.pop_front();
            if (ch !== want.ch || fin !== want.fin || count !== want.count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %h/%b/%0d, got %h/%b/%0d",
                             want.ch, want.fin, want.count, ch, fin, count);
            end
        endfunction

        function int pending();
            return text_q.size();
        endfunction
    endclass

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                src_valid  = 1'b0;
    logic                src_stall;
    logic                cmd        = CMD_SIGNED;
    logic [VALUE_W-1:0]  value      = '0;
    logic                dst_valid;
    logic                dst_stall  = 1'b0;
    logic [CHAR_W-1:0]   ascii_char;
    logic                last;
    logic [COUNT_W-1:0]  char_count;

    int            tx_idle_pct = 0;
    int            rx_idle_pct = 0;
    logic          hold_req    = 1'b0;
    dec_text_board board       = new();

    int_to_decimal_ascii u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .cmd        (cmd),
        .value      (value),
        .dst_valid  (dst_valid),
        .dst_stall  (dst_stall),
        .ascii_char (ascii_char),
        .last       (last),
        .char_count (char_count)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin : receiver
        logic hold_done;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                dst_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            dst_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && dst_valid && !dst_stall)
            board.check_char(ascii_char, last, char_count);
    end

    task automatic send_number(input logic mode, input logic [VALUE_W-1:0] raw);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        cmd       <= mode;
        value     <= raw;
        do
            @(posedge clk);
        while (src_stall);
        board.note_number(mode, raw);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = $urandom_range(999);
            2: v = $urandom >> $urandom_range(31);
            default: v = -VALUE_W'($urandom_range(99999));
        endcase
        return v;
    endfunction

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++)
            send_number($urandom_range(1) ? CMD_UNSIGNED : CMD_SIGNED, pick_value());
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_number(CMD_SIGNED,   32'd0);
        send_number(CMD_UNSIGNED, 32'd0);
        send_number(CMD_SIGNED,   32'd1);
        send_number(CMD_UNSIGNED, 32'd9);
        send_number(CMD_SIGNED,   32'd10);
        send_number(CMD_UNSIGNED, 32'd99);
        send_number(CMD_SIGNED,   32'd100);
        send_number(CMD_SIGNED,   32'hFFFF_FFFF);
        send_number(CMD_UNSIGNED, 32'hFFFF_FFFF);
        send_number(CMD_SIGNED,   32'h8000_0000);
        send_number(CMD_UNSIGNED, 32'h8000_0000);
        send_number(CMD_SIGNED,   32'h7FFF_FFFF);
        send_number(CMD_UNSIGNED, 32'h7FFF_FFFF);
        send_number(CMD_SIGNED,   -32'sd10);
        send_number(CMD_SIGNED,   -32'sd9);
        send_number(CMD_SIGNED,   32'd999_999_999);
        send_number(CMD_UNSIGNED, 32'd1_000_000_000);
        send_number(CMD_UNSIGNED, 32'd4_000_000_000);
        send_number(CMD_SIGNED,   32'hAAAA_AAAA);
        send_number(CMD_UNSIGNED, 32'hAAAA_AAAA);
        send_number(CMD_SIGNED,   32'h5555_5555);
        send_number(CMD_UNSIGNED, 32'h8000_0001);

        tx_idle_pct = 21;
        rx_idle_pct = 47;
        send_random(RANDOM_ITEMS);

        tx_idle_pct = 47;
        rx_idle_pct = 21;
        send_random(RANDOM_ITEMS);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req   <= 1'b1;
        send_random(RANDOM_ITEMS);

        src_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (board.mismatches == 0 && board.pending() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
